// ----- sv/srdb_pkg.sv -----
// Shared types and constants for the sequence reorder delivery buffer.
// Holds the descriptor layout, status codes, sequencer states and the
// control and condition structs passed between the sequencer and datapath.
package srdb_pkg;

  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned REL_W    = 7;
  localparam logic        OP_PUSH  = 1'b0;
  localparam logic        OP_POP   = 1'b1;

  // Descriptor: handle in bits 15..0, length in 27..16, send flag in bit 28.
  typedef struct packed {
    logic                send;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } slot_t;

  localparam int unsigned DESC_W = $bits(desc_t);
  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STALE  = 2'd1,
    ST_BEYOND = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STORE,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_FIFO_RD,
    S_FIFO_CHK,
    S_DONE
  } state_t;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic cfg_we;
    logic in_valid;
    logic is_pop;
    logic in_window;
    logic clr_last;
    logic slot_hit;
    logic fifo_empty;
    logic head_send;
    logic out_free;
  } cond_t;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic store_wr;
    logic slot_rd;
    logic release_slot;
    logic fifo_rd;
    logic set_empty;
    logic skip;
    logic pop_take;
    logic load_out;
  } ctrl_t;

endpackage

// ----- sv/sequence_reorder_delivery_buffer_top.sv -----
// Top level of the sequence reorder delivery buffer: datapath registers,
// the slot store and delivery queue memories, and the sequencer.
// Depends on srdb_pkg, srdb_ram and srdb_fsm.
//
//   Channel  Direction  Handshake              Payload
//   in_      in         in_valid / in_stall    op, seq_num, packet_handle,
//                                              data_length, send_flag, max_bytes
//   out_     out        out_valid / out_stall  status, next_expected,
//                                              released_count, handle,
//                                              byte_offset, byte_count,
//                                              packet_done
//   cfg_     in         cfg_wr_en              initial_sequence
//
// Every item is taken in the idle step. A dropped push goes straight to
// the final step; an in-window push stores its descriptor and then walks
// the slot ring, releasing packets; a pop walks the delivery queue, skipping
// send packets. Each memory has a single read port, so every slot or queue
// entry examined takes a read step and a check step.
// Reset, and every configuration write, start a clearing pass over every
// entry of the slot store, during which in_stall is held high.
// A finished result sits in the output register while the next item is
// taken; a result that is still waiting holds the sequencer in its final
// step until out_stall falls.
module sequence_reorder_delivery_buffer_top
  import srdb_pkg::*;
#(
  parameter int unsigned WINDOW         = 64,
  parameter int unsigned DELIVERY_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration
  input  logic                cfg_wr_en,
  input  logic [SEQ_W-1:0]    cfg_wr_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [SEQ_W-1:0]    in_seq_num,
  input  logic [HANDLE_W-1:0] in_packet_handle,
  input  logic [LEN_W-1:0]    in_data_length,
  input  logic                in_send_flag,
  input  logic [LEN_W-1:0]    in_max_bytes,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [SEQ_W-1:0]    out_next_expected,
  output logic [REL_W-1:0]    out_released_count,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [LEN_W-1:0]    out_byte_offset,
  output logic [LEN_W-1:0]    out_byte_count,
  output logic                out_packet_done
);

  // Slot ring index, queue index and queue occupancy widths.
  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned HW = $clog2(DELIVERY_DEPTH);
  localparam int unsigned CW = $clog2(DELIVERY_DEPTH + 1);

  ctrl_t ctrl;
  cond_t cond;

  // Control state, cleared by reset.
  logic [SEQ_W-1:0] expected_r, expected_nxt;
  logic [SW-1:0]    ring_base_r, ring_base_nxt;
  logic [SW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [HW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [LEN_W-1:0] roff_r, roff_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Item and result working registers.
  desc_t            desc_r, desc_nxt;
  logic [LEN_W-1:0] maxb_r, maxb_nxt;
  logic [SW-1:0]    dist_r, dist_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [REL_W-1:0] res_rel_r, res_rel_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [LEN_W-1:0] res_offs_r, res_offs_nxt;
  logic [LEN_W-1:0] res_cnt_r, res_cnt_nxt;
  logic             res_done_r, res_done_nxt;

  // Output register.
  status_t          o_status_r, o_status_nxt;
  logic [SEQ_W-1:0] o_expected_r, o_expected_nxt;
  logic [REL_W-1:0] o_rel_r, o_rel_nxt;
  logic [HANDLE_W-1:0] o_handle_r, o_handle_nxt;
  logic [LEN_W-1:0] o_offs_r, o_offs_nxt;
  logic [LEN_W-1:0] o_cnt_r, o_cnt_nxt;
  logic             o_done_r, o_done_nxt;

  // Memory ports.
  logic              slot_we;
  logic [SW-1:0]     slot_waddr;
  slot_t             slot_wdata;
  logic [SLOT_W-1:0] slot_rdata_raw;
  slot_t             slot_rdata;
  logic              fifo_we;
  logic [HW-1:0]     fifo_waddr;
  logic [DESC_W-1:0] fifo_rdata_raw;
  desc_t             fifo_rdata;

  // Shared arithmetic.
  logic [SEQ_W-1:0] dist_in;
  logic             in_fire;
  logic             in_window;
  logic [SW:0]      slot_sum;
  logic [SW-1:0]    slot_addr;
  logic [SW-1:0]    ring_inc;
  logic [HW-1:0]    head_inc;
  logic [CW:0]      tail_sum;
  logic [HW-1:0]    tail_addr;
  logic             fifo_full;
  logic [LEN_W:0]   pop_sum;
  logic             pop_fin;

  assign in_fire = in_valid && ctrl.accept;
  assign in_stall = !ctrl.accept;

  // Serial-number distance from the expected sequence number.
  assign dist_in   = in_seq_num - expected_r;
  assign in_window = dist_in < SEQ_W'(WINDOW);

  // Ring arithmetic: each sum stays below twice the modulus, so one
  // compare and subtract brings the sum back into range.
  assign slot_sum  = {1'b0, ring_base_r} + {1'b0, dist_r};
  assign slot_addr = (slot_sum >= (SW + 1)'(WINDOW)) ?
                     SW'(slot_sum - (SW + 1)'(WINDOW)) : SW'(slot_sum);
  assign ring_inc  = (ring_base_r == SW'(WINDOW - 1)) ? '0 : ring_base_r + SW'(1);
  assign head_inc  = (head_r == HW'(DELIVERY_DEPTH - 1)) ? '0 : head_r + HW'(1);
  assign tail_sum  = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail_addr = (tail_sum >= (CW + 1)'(DELIVERY_DEPTH)) ?
                     HW'(tail_sum - (CW + 1)'(DELIVERY_DEPTH)) : HW'(tail_sum);
  assign fifo_full = count_r == CW'(DELIVERY_DEPTH);

  // Pop: the head packet is finished once the offset plus the request
  // reaches its length.
  assign pop_sum = {1'b0, roff_r} + {1'b0, maxb_r};
  assign pop_fin = pop_sum >= {1'b0, fifo_rdata.len};

  assign slot_rdata = slot_t'(slot_rdata_raw);
  assign fifo_rdata = desc_t'(fifo_rdata_raw);

  always_comb begin
    cond            = '0;
    cond.cfg_we     = cfg_wr_en;
    cond.in_valid   = in_valid;
    cond.is_pop     = in_op == OP_POP;
    cond.in_window  = in_window;
    cond.clr_last   = clr_cnt_r == SW'(WINDOW - 1);
    cond.slot_hit   = slot_rdata.valid && !fifo_full;
    cond.fifo_empty = count_r == '0;
    cond.head_send  = fifo_rdata.send;
    cond.out_free   = !out_valid_r || !out_stall;
  end

  // Slot store write port: clearing pass, descriptor store, or release.
  always_comb begin
    slot_we    = ctrl.clr_wr || ctrl.store_wr || ctrl.release_slot;
    slot_waddr = ring_base_r;
    slot_wdata = '0;
    if (ctrl.clr_wr) begin
      slot_waddr = clr_cnt_r;
    end else if (ctrl.store_wr) begin
      slot_waddr       = slot_addr;
      slot_wdata.valid = 1'b1;
      slot_wdata.desc  = desc_r;
    end
  end

  assign fifo_we    = ctrl.release_slot;
  assign fifo_waddr = tail_addr;

  srdb_ram #(
    .DEPTH (WINDOW),
    .WIDTH (SLOT_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_en   (ctrl.slot_rd),
    .rd_addr (ring_base_r),
    .rd_data (slot_rdata_raw)
  );

  srdb_ram #(
    .DEPTH (DELIVERY_DEPTH),
    .WIDTH (DESC_W)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (fifo_waddr),
    .wr_data (slot_rdata.desc),
    .rd_en   (ctrl.fifo_rd),
    .rd_addr (head_r),
    .rd_data (fifo_rdata_raw)
  );

  srdb_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  always_comb begin
    expected_nxt   = expected_r;
    ring_base_nxt  = ring_base_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    roff_nxt       = roff_r;
    desc_nxt       = desc_r;
    maxb_nxt       = maxb_r;
    dist_nxt       = dist_r;
    res_status_nxt = res_status_r;
    res_rel_nxt    = res_rel_r;
    res_handle_nxt = res_handle_r;
    res_offs_nxt   = res_offs_r;
    res_cnt_nxt    = res_cnt_r;
    res_done_nxt   = res_done_r;

    if (cfg_wr_en) begin
      // A new connection: load the expected number and rebase the ring.
      // The delivery queue and its read offset are kept.
      expected_nxt  = cfg_wr_data;
      ring_base_nxt = '0;
      clr_cnt_nxt   = '0;
    end else begin
      if (ctrl.clr_wr) begin
        clr_cnt_nxt = clr_cnt_r + SW'(1);
      end

      if (in_fire) begin
        desc_nxt.handle = in_packet_handle;
        desc_nxt.len    = in_data_length;
        desc_nxt.send   = in_send_flag;
        maxb_nxt        = in_max_bytes;
        dist_nxt        = SW'(dist_in);
        res_rel_nxt     = '0;
        res_handle_nxt  = '0;
        res_offs_nxt    = '0;
        res_cnt_nxt     = '0;
        res_done_nxt    = 1'b0;
        if (in_op == OP_POP || in_window) begin
          res_status_nxt = ST_OK;
        end else if (dist_in[SEQ_W-1]) begin
          res_status_nxt = ST_STALE;
        end else begin
          res_status_nxt = ST_BEYOND;
        end
      end

      if (ctrl.release_slot) begin
        expected_nxt  = expected_r + SEQ_W'(1);
        ring_base_nxt = ring_inc;
        count_nxt     = count_r + CW'(1);
        if (res_rel_r != '1) begin
          res_rel_nxt = res_rel_r + REL_W'(1);
        end
      end

      if (ctrl.set_empty) begin
        res_status_nxt = ST_EMPTY;
      end

      if (ctrl.skip) begin
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
      end

      if (ctrl.pop_take) begin
        res_handle_nxt = fifo_rdata.handle;
        res_offs_nxt   = roff_r;
        res_done_nxt   = pop_fin;
        if (pop_fin) begin
          res_cnt_nxt = (fifo_rdata.len >= roff_r) ? fifo_rdata.len - roff_r : '0;
          head_nxt    = head_inc;
          count_nxt   = count_r - CW'(1);
          roff_nxt    = '0;
        end else begin
          res_cnt_nxt = maxb_r;
          roff_nxt    = pop_sum[LEN_W-1:0];
        end
      end
    end
  end

  // Output register and its valid bit.
  always_comb begin
    o_status_nxt   = o_status_r;
    o_expected_nxt = o_expected_r;
    o_rel_nxt      = o_rel_r;
    o_handle_nxt   = o_handle_r;
    o_offs_nxt     = o_offs_r;
    o_cnt_nxt      = o_cnt_r;
    o_done_nxt     = o_done_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (ctrl.load_out) begin
      o_status_nxt   = res_status_r;
      o_expected_nxt = expected_r;
      o_rel_nxt      = res_rel_r;
      o_handle_nxt   = res_handle_r;
      o_offs_nxt     = res_offs_r;
      o_cnt_nxt      = res_cnt_r;
      o_done_nxt     = res_done_r;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      ring_base_r <= '0;
      clr_cnt_r   <= '0;
      head_r      <= '0;
      count_r     <= '0;
      roff_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      expected_r  <= expected_nxt;
      ring_base_r <= ring_base_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      roff_r      <= roff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r       <= desc_nxt;
    maxb_r       <= maxb_nxt;
    dist_r       <= dist_nxt;
    res_status_r <= res_status_nxt;
    res_rel_r    <= res_rel_nxt;
    res_handle_r <= res_handle_nxt;
    res_offs_r   <= res_offs_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_done_r   <= res_done_nxt;
    o_status_r   <= o_status_nxt;
    o_expected_r <= o_expected_nxt;
    o_rel_r      <= o_rel_nxt;
    o_handle_r   <= o_handle_nxt;
    o_offs_r     <= o_offs_nxt;
    o_cnt_r      <= o_cnt_nxt;
    o_done_r     <= o_done_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_next_expected  = o_expected_r;
  assign out_released_count = o_rel_r;
  assign out_handle         = o_handle_r;
  assign out_byte_offset    = o_offs_r;
  assign out_byte_count     = o_cnt_r;
  assign out_packet_done    = o_done_r;

endmodule

// ----- sv/srdb_ram.sv -----
// Simple dual-port memory: one write port and one read port with registered
// read data. Used for the slot store and for the delivery queue.
// No dependencies.
module srdb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 30,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/srdb_fsm.sv -----
// Sequencer of the reorder buffer: steps the shared datapath through the
// clearing pass, slot store, release walk and pop walk.
// Depends on srdb_pkg.
module srdb_fsm
  import srdb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cond_t cond,
  output ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cond.cfg_we) begin
      state_nxt = S_CLEAR;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (cond.clr_last) begin
            state_nxt = S_IDLE;
          end
        end
        S_IDLE: begin
          if (cond.in_valid) begin
            if (cond.is_pop) begin
              state_nxt = S_FIFO_RD;
            end else if (cond.in_window) begin
              state_nxt = S_STORE;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
        S_STORE:    state_nxt = S_SLOT_RD;
        S_SLOT_RD:  state_nxt = S_SLOT_CHK;
        S_SLOT_CHK: state_nxt = cond.slot_hit ? S_SLOT_RD : S_DONE;
        S_FIFO_RD:  state_nxt = cond.fifo_empty ? S_DONE : S_FIFO_CHK;
        S_FIFO_CHK: state_nxt = cond.head_send ? S_FIFO_RD : S_DONE;
        S_DONE: begin
          if (cond.out_free) begin
            state_nxt = S_IDLE;
          end
        end
        default:    state_nxt = S_CLEAR;
      endcase
    end
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      S_CLEAR:    ctrl.clr_wr = 1'b1;
      S_IDLE:     ctrl.accept = !cond.cfg_we;
      S_STORE:    ctrl.store_wr = 1'b1;
      S_SLOT_RD:  ctrl.slot_rd = 1'b1;
      S_SLOT_CHK: ctrl.release_slot = cond.slot_hit;
      S_FIFO_RD: begin
        ctrl.fifo_rd   = !cond.fifo_empty;
        ctrl.set_empty = cond.fifo_empty;
      end
      S_FIFO_CHK: begin
        ctrl.skip     = cond.head_send;
        ctrl.pop_take = !cond.head_send;
      end
      S_DONE:     ctrl.load_out = cond.out_free;
      default:    ctrl = '0;
    endcase
  end

endmodule

// ----- tb/sv/sequence_reorder_delivery_buffer_top_tb.sv -----
// Self-checking testbench for the sequence reorder delivery buffer.
// Depends on srdb_pkg and the RTL under sv/; drives push and pop transfers and
// checks every result against an in-bench model of the reorder and delivery.
module sequence_reorder_delivery_buffer_top_tb
  import srdb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Sizes match the defaults of the block under test.
  localparam int WINDOW      = 64;
  localparam int DEPTH       = 64;
  // Receiver hold-off used to back the block up, and the watchdog limit. The
  // limit covers the hold-off, a clearing pass and the slowest single item.
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 3000;

  // One input transfer as it is offered on the in_ channel.
  typedef struct packed {
    logic                op;
    logic [SEQ_W-1:0]    seq_num;
    logic [HANDLE_W-1:0] packet_handle;
    logic [LEN_W-1:0]    data_length;
    logic                send_flag;
    logic [LEN_W-1:0]    max_bytes;
  } offer_t;

  // What one item is predicted to return on the out_ channel.
  typedef struct packed {
    status_t             status;
    logic [SEQ_W-1:0]    next_expected;
    logic [REL_W-1:0]    released;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    offset;
    logic [LEN_W-1:0]    count;
    logic                done;
  } reorder_outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [SEQ_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = OP_PUSH;
  logic [SEQ_W-1:0]    in_seq_num = '0;
  logic [HANDLE_W-1:0] in_packet_handle = '0;
  logic [LEN_W-1:0]    in_data_length = '0;
  logic                in_send_flag = 1'b0;
  logic [LEN_W-1:0]    in_max_bytes = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [SEQ_W-1:0]    out_next_expected;
  logic [REL_W-1:0]    out_released_count;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    out_byte_offset;
  logic [LEN_W-1:0]    out_byte_count;
  logic                out_packet_done;

  sequence_reorder_delivery_buffer_top #(
    .WINDOW         (WINDOW),
    .DELIVERY_DEPTH (DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_seq_num         (in_seq_num),
    .in_packet_handle   (in_packet_handle),
    .in_data_length     (in_data_length),
    .in_send_flag       (in_send_flag),
    .in_max_bytes       (in_max_bytes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_next_expected  (out_next_expected),
    .out_released_count (out_released_count),
    .out_handle         (out_handle),
    .out_byte_offset    (out_byte_offset),
    .out_byte_count     (out_byte_count),
    .out_packet_done    (out_packet_done)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and results predicted but not yet seen.
  offer_t           offer_q[$];
  reorder_outcome_t outcome_q[$];

  // Flags set by the monitor at the rising edge and read by both drivers at
  // the following falling edge: a transfer took place on that channel.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  // Idling controls. The quiet flags suppress random gaps for a whole phase;
  // hold_start asks the receiver for one long hold-off.
  logic tx_quiet   = 1'b0;
  logic rx_quiet   = 1'b0;
  logic hold_start = 1'b0;
  int   tx_gap     = 0;
  int   rx_gap     = 0;
  int   hold_left  = 0;

  int mismatches   = 0;
  int quiet_cycles = 0;

  // Model state. The slot ring and the delivery queue are kept as the block
  // keeps them, so that the release run and the send skip walk the same
  // entries in the same order.
  logic [SEQ_W-1:0] exp_seq;
  logic             slot_held [WINDOW];
  desc_t            slot_store[WINDOW];
  desc_t            delivery_q[DEPTH];
  int               ring_base;
  int               fifo_head;
  int               fifo_used;
  int               read_off;

  // A new connection or reset forgets every parked descriptor and rebases the
  // ring; a new connection leaves the delivery queue and read offset alone.
  function automatic void clear_slots();
    for (int i = 0; i < WINDOW; i++) slot_held[i] = 1'b0;
    ring_base = 0;
  endfunction

  function automatic void drop_delivery_head();
    fifo_head = (fifo_head + 1) % DEPTH;
    fifo_used--;
  endfunction

  // Applies one accepted item to the model and returns what the block should
  // report for it.
  function automatic reorder_outcome_t reorder_step(input offer_t it);
    reorder_outcome_t res;
    logic [SEQ_W-1:0] seq_gap;
    desc_t            nd;
    int               slot;
    int               released;
    res      = '0;
    released = 0;
    if (it.op == OP_PUSH) begin
      // Serial-number distance from the expected number, modulo 2^16.
      seq_gap = it.seq_num - exp_seq;
      if (seq_gap < WINDOW) begin
        nd.send   = it.send_flag;
        nd.len    = it.data_length;
        nd.handle = it.packet_handle;
        slot = (ring_base + int'(seq_gap)) % WINDOW;
        slot_held[slot]  = 1'b1;
        slot_store[slot] = nd;
        // Move the contiguous run to the delivery queue until a gap or a
        // full queue stops it.
        while (slot_held[ring_base] && fifo_used < DEPTH) begin
          delivery_q[(fifo_head + fifo_used) % DEPTH] = slot_store[ring_base];
          fifo_used++;
          slot_held[ring_base] = 1'b0;
          ring_base = (ring_base + 1) % WINDOW;
          exp_seq   = exp_seq + 1'b1;
          released++;
        end
      end else if (seq_gap >= 16'h8000) begin
        res.status = ST_STALE;
      end else begin
        res.status = ST_BEYOND;
      end
    end else begin
      // Send-type packets at the head are never handed out.
      while (fifo_used > 0 && delivery_q[fifo_head].send) drop_delivery_head();
      if (fifo_used == 0) begin
        res.status = ST_EMPTY;
      end else begin
        nd         = delivery_q[fifo_head];
        res.handle = nd.handle;
        res.offset = LEN_W'(read_off);
        if (read_off + int'(it.max_bytes) >= int'(nd.len)) begin
          res.count = (int'(nd.len) >= read_off) ? LEN_W'(int'(nd.len) - read_off) : '0;
          res.done  = 1'b1;
          drop_delivery_head();
          read_off = 0;
        end else begin
          res.count = it.max_bytes;
          read_off  = read_off + int'(it.max_bytes);
        end
      end
    end
    res.released      = (released > 127) ? REL_W'(127) : REL_W'(released);
    res.next_expected = exp_seq;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: everything is sampled at the rising edge. Results are checked
  // before the item taken on the same edge is predicted, although a result
  // can never belong to an item accepted on the very same edge.
  always @(posedge clk) begin : monitor
    reorder_outcome_t want;
    offer_t           seen;
    if (!rst_n) begin
      clear_slots();
      exp_seq   = '0;
      fifo_head = 0;
      fifo_used = 0;
      read_off  = 0;
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t ns: result transfer with nothing outstanding, expected none, actual status %0h",
                   $time, out_status);
          mismatches++;
        end else begin
          want = outcome_q[0];
          outcome_q.delete(0);
          check_field("status",         16'(want.status),        16'(out_status));
          check_field("next_expected",  want.next_expected,      out_next_expected);
          check_field("released_count", 16'(want.released),      16'(out_released_count));
          check_field("handle",         want.handle,             out_handle);
          check_field("byte_offset",    16'(want.offset),        16'(out_byte_offset));
          check_field("byte_count",     16'(want.count),         16'(out_byte_count));
          check_field("packet_done",    16'(want.done),          16'(out_packet_done));
        end
      end
      // A write of the initial sequence starts a new connection.
      if (cfg_wr_en) begin
        exp_seq = cfg_wr_data;
        clear_slots();
      end
      if (in_valid && !in_stall) begin
        seen.op            = in_op;
        seen.seq_num       = in_seq_num;
        seen.packet_handle = in_packet_handle;
        seen.data_length   = in_data_length;
        seen.send_flag     = in_send_flag;
        seen.max_bytes     = in_max_bytes;
        outcome_q.insert(outcome_q.size(), reorder_step(seen));
      end
    end
  end

  // Sender: a new item is put up only once the previous one has gone, after a
  // random gap drawn per item. The payload never moves while the block stalls
  // it.
  always @(negedge clk) begin : sender
    offer_t it;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_taken) tx_gap = tx_quiet ? 0 : $urandom_range(0, 5);
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (offer_q.size() > 0) begin
        it = offer_q[0];
        offer_q.delete(0);
        in_op            <= it.op;
        in_seq_num       <= it.seq_num;
        in_packet_handle <= it.packet_handle;
        in_data_length   <= it.data_length;
        in_send_flag     <= it.send_flag;
        in_max_bytes     <= it.max_bytes;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: after each result transfer it stalls for a random stretch, and on
  // request holds off for a long stretch that it counts out itself.
  always @(negedge clk) begin : receiver
    if (hold_start) hold_left = LONG_HOLD;
    if (out_taken) rx_gap = rx_quiet ? 0 : $urandom_range(0, 5);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The fields that an operation ignores still carry random values.
  task automatic queue_push(input logic [15:0] seq, input logic [15:0] handle,
                            input logic [11:0] len, input logic send);
    offer_t it;
    it.op            = OP_PUSH;
    it.seq_num       = seq;
    it.packet_handle = handle;
    it.data_length   = len;
    it.send_flag     = send;
    it.max_bytes     = LEN_W'($urandom);
    offer_q.insert(offer_q.size(), it);
  endtask

  task automatic queue_pop(input logic [11:0] max_bytes);
    offer_t it;
    it               = offer_t'($urandom);
    it.seq_num       = SEQ_W'($urandom);
    it.op            = OP_POP;
    it.max_bytes     = max_bytes;
    offer_q.insert(offer_q.size(), it);
  endtask

  // Mostly short packets so that pops keep up, with the odd full-range one.
  function automatic logic [11:0] rand_len();
    case ($urandom_range(0, 7))
      0:       return LEN_W'($urandom);
      1:       return 12'hFFF;
      default: return LEN_W'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic logic [11:0] rand_max_bytes();
    return ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 16)) : LEN_W'($urandom);
  endfunction

  function automatic logic rand_send();
    return ($urandom_range(0, 4) == 0);
  endfunction

  // Blocks until every item has gone and every result has come back; the
  // block then has no work left, since each item makes exactly one result.
  task automatic wait_drained();
    while (!(offer_q.size() == 0 && !in_valid && outcome_q.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Well-formed traffic: consecutive sequence blocks, shuffled within the
  // window, with replacements, stale and beyond-window noise, and pops mixed
  // in at roughly the rate at which packets become deliverable.
  task automatic queue_ordered_traffic(input logic [15:0] first_seq, input int budget,
                                       input int pop_pct);
    logic [15:0] order[64];
    logic [15:0] base;
    logic [15:0] swap;
    int          n;
    int          k;
    int          t;
    int          r;
    base = first_seq;
    n    = 0;
    while (n < budget) begin
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      for (int j = 0; j < k; j++) order[j] = base + 16'(j);
      for (int j = k - 1; j > 0; j--) begin
        t        = $urandom_range(0, j);
        swap     = order[j];
        order[j] = order[t];
        order[t] = swap;
      end
      for (int j = 0; j < k; j++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          queue_push(base - 16'($urandom_range(1, 32000)), 16'($urandom), rand_len(),
                     rand_send());
          n++;
        end else if (r < 12) begin
          queue_push(base + 16'(k) + 16'($urandom_range(64, 30000)), 16'($urandom),
                     rand_len(), rand_send());
          n++;
        end
        queue_push(order[j], 16'($urandom), rand_len(), rand_send());
        n++;
        // A second descriptor for the same number replaces the first while it
        // is still parked, and is stale once the first has been released.
        if ($urandom_range(0, 99) < 8) begin
          queue_push(order[j], 16'($urandom), rand_len(), rand_send());
          n++;
        end
        while ($urandom_range(0, 99) < pop_pct) begin
          queue_pop(rand_max_bytes());
          n++;
        end
      end
      base = base + 16'(k);
    end
  endtask

  // Fills the delivery queue with no pops so that the release run stops on a
  // full queue, parks a few more, drains everything and lets the parked run
  // move on the next accepted push.
  task automatic queue_delivery_overrun(input logic [15:0] first_seq);
    for (int j = 0; j < 70; j++)
      queue_push(first_seq + 16'(j), 16'($urandom), rand_len(), rand_send());
    for (int j = 0; j < 80; j++) queue_pop(12'hFFF);
    queue_push(first_seq + 16'd70, 16'($urandom), rand_len(), rand_send());
  endtask

  // One phase: new connection at first_seq once the block is idle, then the
  // traffic, optionally with a long receiver hold-off at its start.
  task automatic run_phase(input logic [15:0] first_seq, input int budget, input int pop_pct,
                           input logic calm, input logic long_hold, input logic overrun);
    wait_drained();
    @(negedge clk);
    cfg_wr_data <= first_seq;
    cfg_wr_en   <= 1'b1;
    tx_quiet    <= calm;
    rx_quiet    <= calm;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
    if (overrun) queue_delivery_overrun(first_seq);
    else queue_ordered_traffic(first_seq, budget, pop_pct);
    if (long_hold) begin
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset connection whose expected number is 0.
    queue_pop(12'hFFF);                            // nothing queued yet
    queue_push(16'd1, 16'hFFFF, 12'hFFF, 1'b0);    // out of order, parked
    queue_push(16'd0, 16'h0000, 12'h000, 1'b1);    // fills the gap, run of two
    queue_push(16'd1, 16'h1111, 12'h001, 1'b0);    // already delivered: stale
    queue_push(16'd66, 16'h2222, 12'h002, 1'b0);   // first number past the window
    queue_push(16'd65, 16'h1234, 12'h005, 1'b0);   // last number inside the window
    queue_push(16'h8002, 16'h3333, 12'h003, 1'b0); // half-range distance: stale
    queue_push(16'h8001, 16'h4444, 12'h004, 1'b1); // just under half-range: beyond
    queue_push(16'd3, 16'hAAAA, 12'd10, 1'b0);
    queue_push(16'd3, 16'h5555, 12'd10, 1'b0);     // replaces the parked descriptor
    queue_pop(12'h000);                            // skips the send packet, reads nothing
    queue_pop(12'hFFF);                            // finishes the largest packet
    queue_push(16'd2, 16'h0F0F, 12'h000, 1'b0);    // releases 2 and the replaced 3
    queue_pop(12'h000);                            // zero-length packet completes at once
    queue_pop(12'h001);                            // partial read
    queue_pop(12'hFFF);                            // remainder from a non-zero offset
    queue_pop(12'h000);                            // queue empty again

    // Random phases, each a new connection. The extremes of the register and
    // a start just short of the wrap come first.
    run_phase(16'hFFFF,        260, 60, 1'b0, 1'b0, 1'b0);
    run_phase(16'h0000,        200, 60, 1'b1, 1'b0, 1'b0);
    run_phase(16'hFFC0,        250, 60, 1'b0, 1'b1, 1'b0);
    run_phase(16'($urandom),     0,  0, 1'b0, 1'b0, 1'b1);
    run_phase(16'($urandom),   260, 45, 1'b0, 1'b0, 1'b0);
    run_phase(16'($urandom),   260, 70, 1'b0, 1'b0, 1'b0);
    run_phase(16'h7FF0,        160, 60, 1'b0, 1'b0, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
